@@ rtl/tsw_pkg.sv @@
// shared types and constants of the tcp sender window engine
package tsw_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 32;
    localparam int unsigned MAX_RES         = 32;
    localparam int unsigned RES_W           = 6;
    localparam int unsigned FL_W            = 20;
    localparam int unsigned META_W          = 13;

    localparam logic [10:0] PAYLOAD_CAP     = 11'd1452;
    localparam logic [16:0] INFLIGHT_MAX    = 17'd131071;
    localparam logic [31:0] ISN_RST         = 32'd0;
    localparam logic [15:0] TIMEOUT_RST     = 16'd1000;
    localparam logic [10:0] MAXPAY_RST      = 11'd1000;
    localparam logic [15:0] CAPACITY_RST    = 16'd64000;

    // input function codes
    localparam logic [2:0] FUNC_WRITE = 3'd0;
    localparam logic [2:0] FUNC_END   = 3'd1;
    localparam logic [2:0] FUNC_ACK   = 3'd2;
    localparam logic [2:0] FUNC_TICK  = 3'd3;
    localparam logic [2:0] FUNC_FILL  = 3'd4;
    localparam logic [2:0] FUNC_EMPTY = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_ISN      = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_MAXPAY   = 2'd2;
    localparam logic [1:0] REG_CAPACITY = 2'd3;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_END,
        OP_ACK,
        OP_TICK,
        OP_FILL,
        OP_EMPTY,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] byte_count;
        logic [31:0] ack_number;
        logic [15:0] peer_window;
        logic [15:0] elapsed_ms;
    } cmd_t;

    typedef struct packed {
        logic [31:0] isn;
        logic [15:0] initial_timeout;
        logic [10:0] max_payload;
        logic [15:0] stream_capacity;
    } cfg_t;

    function automatic logic [11:0] meta_seqlen(input logic [META_W-1:0] m);
        meta_seqlen = {1'b0, m[10:0]} + {11'd0, m[11]} + {11'd0, m[12]};
    endfunction

endpackage

@@ rtl/tsw_ram.sv @@
// generic single write, single registered read ram
module tsw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/tsw_front.sv @@
// input stage: accepts items, decodes the function and queues commands
module tsw_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic [15:0]        byte_count,
    input  logic [31:0]        ack_number,
    input  logic [15:0]        peer_window,
    input  logic [15:0]        elapsed_ms,
    output logic               cmd_valid,
    input  logic               cmd_pop,
    output tsw_pkg::cmd_t      cmd
);

    tsw_pkg::cmd_t fifo_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    tsw_pkg::op_t  op;
    logic          push;
    logic          pop;

    always_comb
    begin
        unique case (func)
            tsw_pkg::FUNC_WRITE: op = tsw_pkg::OP_WRITE;
            tsw_pkg::FUNC_END:   op = tsw_pkg::OP_END;
            tsw_pkg::FUNC_ACK:   op = tsw_pkg::OP_ACK;
            tsw_pkg::FUNC_TICK:  op = tsw_pkg::OP_TICK;
            tsw_pkg::FUNC_FILL:  op = tsw_pkg::OP_FILL;
            tsw_pkg::FUNC_EMPTY: op = tsw_pkg::OP_EMPTY;
            default:             op = tsw_pkg::OP_NOP;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_pop && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= '{op, byte_count, ack_number, peer_window, elapsed_ms};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2) else $error("command queue overfilled");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 && !push) |=> cnt_reg == 2'd0) else $error("queue count grew");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !in_ready) else $error("accepting while full");

endmodule

@@ rtl/tsw_back.sv @@
// execution engine: stream, ack, timer, fill and result sequencing
module tsw_back #(
    parameter int unsigned QUEUE_DEPTH = tsw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tsw_pkg::cfg_t cfg,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    input  tsw_pkg::cmd_t cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          seg_valid,
    output logic [31:0]   seqno,
    output logic [10:0]   payload_len,
    output logic          syn_flag,
    output logic          fin_flag,
    output logic          is_retransmit,
    output logic          last,
    output logic [7:0]    retx_count,
    output logic [16:0]   in_flight,
    output logic [15:0]   accepted_bytes
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned RES_W_L = tsw_pkg::RES_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [tsw_pkg::FL_W-1:0] FL_MAX =
        {{(tsw_pkg::FL_W-17){1'b0}}, tsw_pkg::INFLIGHT_MAX};

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_ACK_CMP, S_ACK_POP, S_FILL_INIT, S_FILL_STEP,
        S_OUT_RD, S_OUT_LOAD, S_OUT_WAIT
    } state_t;

    typedef enum logic [1:0] { M_NONE, M_EMPTY, M_RETX, M_FILL } mode_t;

    state_t        state_reg;
    mode_t         mode_reg;
    tsw_pkg::cmd_t cmd_reg;

    logic [63:0] next_abs_reg;
    logic [63:0] acked_abs_reg;
    logic [63:0] head_start_reg;
    logic [63:0] ack_abs_reg;
    logic [15:0] window_reg;
    logic        syn_sent_reg;
    logic        fin_sent_reg;
    logic [15:0] buffered_reg;
    logic        ended_reg;
    logic [31:0] elapsed_reg;
    logic [31:0] timeout_reg;
    logic [7:0]  retry_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;
    logic [15:0] accepted_reg;
    logic [15:0] room_reg;
    logic [RES_W_L-1:0] nseg_reg;
    logic [RES_W_L-1:0] oidx_reg;
    logic [PTR_W-1:0]   cur_reg;
    logic [63:0] fill_seq_reg;

    logic                       ram_we;
    logic [PTR_W-1:0]           ram_raddr;
    logic [tsw_pkg::META_W-1:0] ram_rdata;
    logic [tsw_pkg::META_W-1:0] push_meta;

    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_next;
    logic [PTR_W-1:0] cur_next;

    // stream write
    logic [15:0] free_sp;
    logic [15:0] accept_amt;
    // ack unwrap
    logic [31:0] off;
    logic [31:0] lo_part;
    logic [31:0] up_part;
    logic [63:0] unwrapped;
    // timer
    logic [32:0] el_sum;
    logic [31:0] el_sat;
    // fill
    logic [15:0] eff_win;
    logic [tsw_pkg::FL_W-1:0] fl_raw;
    logic [tsw_pkg::FL_W-1:0] fl_now;
    logic [10:0] maxp;
    logic        syn_bit;
    logic [15:0] room_syn;
    logic [15:0] take;
    logic        fin_bit;
    logic [16:0] syn_take;
    logic [11:0] seglen;
    logic        fill_go;
    logic [11:0] head_len;

    always_comb
    begin
        head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
        cur_next  = (cur_reg == PTR_LAST) ? '0 : cur_reg + 1'b1;

        free_sp    = (ended_reg || buffered_reg >= cfg.stream_capacity) ? 16'd0
                     : cfg.stream_capacity - buffered_reg;
        accept_amt = (cmd_reg.byte_count < free_sp) ? cmd_reg.byte_count : free_sp;

        off     = cmd_reg.ack_number - cfg.isn;
        lo_part = acked_abs_reg[31:0];
        up_part = acked_abs_reg[63:32];
        if (off > lo_part && (off - lo_part) > 32'h8000_0000 && up_part != 32'd0)
            unwrapped = {up_part - 32'd1, off};
        else if (off < lo_part && (lo_part - off) > 32'h8000_0000)
            unwrapped = {up_part + 32'd1, off};
        else
            unwrapped = {up_part, off};

        el_sum = {1'b0, elapsed_reg} + {17'd0, cmd_reg.elapsed_ms};
        el_sat = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];

        // in-flight span is bounded by the queue depth times the largest segment
        eff_win = (window_reg != 16'd0) ? window_reg : 16'd1;
        fl_raw  = next_abs_reg[tsw_pkg::FL_W-1:0] - head_start_reg[tsw_pkg::FL_W-1:0];
        fl_now  = (count_reg == '0) ? '0 : fl_raw;

        maxp     = (cfg.max_payload > tsw_pkg::PAYLOAD_CAP) ? tsw_pkg::PAYLOAD_CAP
                   : cfg.max_payload;
        syn_bit  = !syn_sent_reg;
        room_syn = room_reg - {15'd0, syn_bit};
        take     = {5'd0, maxp};
        if (take > room_syn)
            take = room_syn;
        if (take > buffered_reg)
            take = buffered_reg;
        syn_take = {16'd0, syn_bit} + {1'b0, take};
        fin_bit  = ended_reg && (take == buffered_reg) && ({1'b0, room_reg} > syn_take);
        seglen   = {11'd0, syn_bit} + take[11:0] + {11'd0, fin_bit};
        fill_go  = (room_reg != 16'd0) && (count_reg < CNT_FULL)
                   && (nseg_reg != RES_W_L'(tsw_pkg::MAX_RES)) && !fin_sent_reg
                   && (seglen != 12'd0);
        push_meta = {fin_bit, syn_bit, take[10:0]};

        head_len = tsw_pkg::meta_seqlen(ram_rdata);

        ram_we = (state_reg == S_FILL_STEP) && fill_go;
        case (state_reg)
            S_ACK_POP: ram_raddr = head_next;
            S_OUT_RD:  ram_raddr = cur_reg;
            default:   ram_raddr = head_reg;
        endcase
    end

    tsw_ram #(
        .WIDTH (tsw_pkg::META_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_meta_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (push_meta),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= M_NONE;
            cmd_reg        <= '0;
            next_abs_reg   <= '0;
            acked_abs_reg  <= '0;
            head_start_reg <= '0;
            ack_abs_reg    <= '0;
            window_reg     <= 16'd1;
            syn_sent_reg   <= 1'b0;
            fin_sent_reg   <= 1'b0;
            buffered_reg   <= '0;
            ended_reg      <= 1'b0;
            elapsed_reg    <= '0;
            timeout_reg    <= {16'd0, tsw_pkg::TIMEOUT_RST};
            retry_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            accepted_reg   <= '0;
            room_reg       <= '0;
            nseg_reg       <= '0;
            oidx_reg       <= '0;
            cur_reg        <= '0;
            fill_seq_reg   <= '0;
            out_valid      <= 1'b0;
            seg_valid      <= 1'b0;
            seqno          <= '0;
            payload_len    <= '0;
            syn_flag       <= 1'b0;
            fin_flag       <= 1'b0;
            is_retransmit  <= 1'b0;
            last           <= 1'b0;
            retx_count     <= '0;
            in_flight      <= '0;
            accepted_bytes <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg      <= cmd;
                        accepted_reg <= '0;
                        mode_reg     <= M_NONE;
                        state_reg    <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    unique case (cmd_reg.op)
                        tsw_pkg::OP_WRITE:
                        begin
                            accepted_reg <= accept_amt;
                            buffered_reg <= buffered_reg + accept_amt;
                            state_reg    <= S_OUT_LOAD;
                        end
                        tsw_pkg::OP_END:
                        begin
                            ended_reg <= 1'b1;
                            state_reg <= S_OUT_LOAD;
                        end
                        tsw_pkg::OP_ACK:
                        begin
                            ack_abs_reg <= unwrapped;
                            state_reg   <= S_ACK_CMP;
                        end
                        tsw_pkg::OP_TICK:
                        begin
                            if (count_reg == '0)
                                state_reg <= S_OUT_LOAD;
                            else if (el_sat < timeout_reg)
                            begin
                                elapsed_reg <= el_sat;
                                state_reg   <= S_OUT_LOAD;
                            end
                            else
                            begin
                                // timeout: resend the oldest segment
                                mode_reg    <= M_RETX;
                                elapsed_reg <= '0;
                                cur_reg     <= head_reg;
                                if (window_reg != 16'd0)
                                begin
                                    if (retry_reg != 8'hFF)
                                        retry_reg <= retry_reg + 8'd1;
                                    timeout_reg <= timeout_reg[31] ? 32'hFFFF_FFFF
                                                   : {timeout_reg[30:0], 1'b0};
                                end
                                state_reg <= S_OUT_RD;
                            end
                        end
                        tsw_pkg::OP_FILL:
                            state_reg <= S_FILL_INIT;
                        tsw_pkg::OP_EMPTY:
                        begin
                            mode_reg  <= M_EMPTY;
                            state_reg <= S_OUT_LOAD;
                        end
                        default:
                            state_reg <= S_OUT_LOAD;
                    endcase
                end
                S_ACK_CMP:
                begin
                    if (ack_abs_reg < acked_abs_reg || ack_abs_reg > next_abs_reg)
                        state_reg <= S_OUT_LOAD;
                    else
                    begin
                        acked_abs_reg <= ack_abs_reg;
                        window_reg    <= cmd_reg.peer_window;
                        // ram is reading the head entry this cycle
                        state_reg     <= (count_reg == '0) ? S_FILL_INIT : S_ACK_POP;
                    end
                end
                S_ACK_POP:
                begin
                    if (head_start_reg + {52'd0, head_len} > ack_abs_reg)
                        state_reg <= S_FILL_INIT;
                    else
                    begin
                        head_reg       <= head_next;
                        count_reg      <= count_reg - 1'b1;
                        head_start_reg <= head_start_reg + {52'd0, head_len};
                        timeout_reg    <= {16'd0, cfg.initial_timeout};
                        retry_reg      <= '0;
                        elapsed_reg    <= '0;
                        if (count_reg == CNT_W'(1))
                            state_reg <= S_FILL_INIT;
                    end
                end
                S_FILL_INIT:
                begin
                    nseg_reg     <= '0;
                    cur_reg      <= tail_reg;
                    fill_seq_reg <= next_abs_reg;
                    if (fl_now >= {{(tsw_pkg::FL_W-16){1'b0}}, eff_win})
                        state_reg <= S_OUT_LOAD;
                    else
                    begin
                        room_reg  <= eff_win - fl_now[15:0];
                        state_reg <= S_FILL_STEP;
                    end
                end
                S_FILL_STEP:
                begin
                    if (fill_go)
                    begin
                        if (count_reg == '0)
                        begin
                            timeout_reg    <= {16'd0, cfg.initial_timeout};
                            elapsed_reg    <= '0;
                            head_start_reg <= next_abs_reg;
                        end
                        tail_reg     <= tail_next;
                        count_reg    <= count_reg + 1'b1;
                        room_reg     <= room_reg - {4'd0, seglen};
                        next_abs_reg <= next_abs_reg + {52'd0, seglen};
                        buffered_reg <= buffered_reg - take;
                        if (syn_bit)
                            syn_sent_reg <= 1'b1;
                        if (fin_bit)
                            fin_sent_reg <= 1'b1;
                        nseg_reg <= nseg_reg + 1'b1;
                    end
                    else
                    begin
                        oidx_reg <= '0;
                        if (nseg_reg == '0)
                            state_reg <= S_OUT_LOAD;
                        else
                        begin
                            mode_reg  <= M_FILL;
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                S_OUT_RD:
                    state_reg <= S_OUT_LOAD;
                S_OUT_LOAD:
                begin
                    out_valid      <= 1'b1;
                    retx_count     <= retry_reg;
                    in_flight      <= (fl_now > FL_MAX) ? tsw_pkg::INFLIGHT_MAX
                                      : fl_now[16:0];
                    accepted_bytes <= accepted_reg;
                    is_retransmit  <= (mode_reg == M_RETX);
                    unique case (mode_reg)
                        M_NONE:
                        begin
                            seg_valid   <= 1'b0;
                            seqno       <= '0;
                            payload_len <= '0;
                            syn_flag    <= 1'b0;
                            fin_flag    <= 1'b0;
                            last        <= 1'b1;
                        end
                        M_EMPTY:
                        begin
                            seg_valid   <= 1'b1;
                            seqno       <= next_abs_reg[31:0] + cfg.isn;
                            payload_len <= '0;
                            syn_flag    <= 1'b0;
                            fin_flag    <= 1'b0;
                            last        <= 1'b1;
                        end
                        M_RETX:
                        begin
                            seg_valid   <= 1'b1;
                            seqno       <= head_start_reg[31:0] + cfg.isn;
                            payload_len <= ram_rdata[10:0];
                            syn_flag    <= ram_rdata[11];
                            fin_flag    <= ram_rdata[12];
                            last        <= 1'b1;
                        end
                        default:
                        begin
                            seg_valid    <= 1'b1;
                            seqno        <= fill_seq_reg[31:0] + cfg.isn;
                            payload_len  <= ram_rdata[10:0];
                            syn_flag     <= ram_rdata[11];
                            fin_flag     <= ram_rdata[12];
                            last         <= (oidx_reg + 1'b1 == nseg_reg);
                            fill_seq_reg <= fill_seq_reg + {52'd0, head_len};
                        end
                    endcase
                    state_reg <= S_OUT_WAIT;
                end
                default:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        if (last)
                            state_reg <= S_IDLE;
                        else
                        begin
                            oidx_reg  <= oidx_reg + 1'b1;
                            cur_reg   <= cur_next;
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
            endcase
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL) else $error("outstanding queue overfilled");
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT_WAIT) else $error("result shown outside wait");
    a_res_limit: assert property (@(posedge clk) disable iff (!rst_n)
        nseg_reg <= RES_W_L'(tsw_pkg::MAX_RES)) else $error("too many segments in one fill");
    a_ack_order: assert property (@(posedge clk) disable iff (!rst_n)
        acked_abs_reg <= next_abs_reg) else $error("ack beyond next sequence");
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !out_valid) else $error("command taken while result pending");

endmodule

@@ rtl/tcp_sender_window_retransmit.sv @@
// top level of the tcp sender window and retransmit engine
// TCP sender control engine. Each input item (write, end of stream, ack, ms tick, fill,
// empty segment) yields one or more result items; a segment result carries the wrapped
// seqno, payload length, SYN/FIN and a retransmit mark, while the payload bytes stay in
// an outside buffer indexed by sequence number. An item with no segment gives one
// result with seg_valid low. The status fields (retx_count, in_flight, accepted_bytes)
// hold the values after the whole item in every result of that item. A front stage
// decodes items into a two-entry command queue; the back engine runs one command at a
// time: an accepted ack pops each fully acked queue entry and then runs a fill, a fill
// adds one segment at a time, and each fill or retransmit result is read through the
// single read port of the outstanding-segment memory. Up to 32 segments per item.
module tcp_sender_window_retransmit #(
    parameter int unsigned QUEUE_DEPTH = tsw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [15:0] byte_count,
    input  logic [31:0] ack_number,
    input  logic [15:0] peer_window,
    input  logic [15:0] elapsed_ms,
    // result items
    output logic        out_valid,
    input  logic        out_ready,
    output logic        seg_valid,
    output logic [31:0] seqno,
    output logic [10:0] payload_len,
    output logic        syn_flag,
    output logic        fin_flag,
    output logic        is_retransmit,
    output logic        last,
    output logic [7:0]  retx_count,
    output logic [16:0] in_flight,
    output logic [15:0] accepted_bytes
);

    tsw_pkg::cfg_t cfg_reg;
    tsw_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_pop;

    // configuration registers; the user must write them only while the engine is idle (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.isn             <= tsw_pkg::ISN_RST;
            cfg_reg.initial_timeout <= tsw_pkg::TIMEOUT_RST;
            cfg_reg.max_payload     <= tsw_pkg::MAXPAY_RST;
            cfg_reg.stream_capacity <= tsw_pkg::CAPACITY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsw_pkg::REG_ISN:      cfg_reg.isn             <= cfg_wdata;
                tsw_pkg::REG_TIMEOUT:  cfg_reg.initial_timeout <= cfg_wdata[15:0];
                tsw_pkg::REG_MAXPAY:   cfg_reg.max_payload     <= cfg_wdata[10:0];
                default:               cfg_reg.stream_capacity <= cfg_wdata[15:0];
            endcase
        end
    end

    // decode and command queue
    tsw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .byte_count  (byte_count),
        .ack_number  (ack_number),
        .peer_window (peer_window),
        .elapsed_ms  (elapsed_ms),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd)
    );

    // sender state, outstanding queue and result sequencing
    tsw_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd_valid      (cmd_valid),
        .cmd_pop        (cmd_pop),
        .cmd            (cmd),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .seg_valid      (seg_valid),
        .seqno          (seqno),
        .payload_len    (payload_len),
        .syn_flag       (syn_flag),
        .fin_flag       (fin_flag),
        .is_retransmit  (is_retransmit),
        .last           (last),
        .retx_count     (retx_count),
        .in_flight      (in_flight),
        .accepted_bytes (accepted_bytes)
    );

endmodule
